@@ rtl/dbbf_pkg.sv @@
// Shared types, constants, coefficient tables and microcode for the dual-band filter bank.
package dbbf_pkg;

  localparam int SAMPLE_WIDTH   = 12;
  localparam int STATE_WIDTH    = 32;
  localparam int COEF_WIDTH     = 12;
  localparam int GAIN_WIDTH     = 5;
  localparam int OFFSET_WIDTH   = 10;
  localparam int OUT_WIDTH      = 16;
  localparam int SECTIONS       = 4;
  localparam int SEC_WIDTH      = $clog2(SECTIONS);
  localparam int S_TDATA_WIDTH  = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int M_TDATA_WIDTH  = 2 * OUT_WIDTH;
  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;
  localparam int REG_SEL_BIT    = 2;
  localparam int PC_WIDTH       = 3;

  localparam int Q_SHIFT    = 10;
  localparam int B1_SHIFT   = 11;
  localparam int GAIN_SHIFT = 20;

  localparam logic [OFFSET_WIDTH-1:0] OFFSET_RESET = OFFSET_WIDTH'(512);
  localparam logic [GAIN_WIDTH-1:0]   GAIN_RESET   = GAIN_WIDTH'(8);

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_GAIN   = 1'b1;

  localparam logic BAND_LOW  = 1'b0;
  localparam logic BAND_HIGH = 1'b1;

  localparam logic [PC_WIDTH-1:0] STEP_A1     = PC_WIDTH'(0);
  localparam logic [PC_WIDTH-1:0] STEP_A2     = PC_WIDTH'(1);
  localparam logic [PC_WIDTH-1:0] STEP_W      = PC_WIDTH'(2);
  localparam logic [PC_WIDTH-1:0] STEP_Y1     = PC_WIDTH'(3);
  localparam logic [PC_WIDTH-1:0] STEP_B1     = PC_WIDTH'(4);
  localparam logic [PC_WIDTH-1:0] STEP_GAIN   = PC_WIDTH'(5);
  localparam logic [PC_WIDTH-1:0] STEP_OUTPUT = PC_WIDTH'(6);

  localparam logic [SEC_WIDTH-1:0] LAST_SECTION = SEC_WIDTH'(SECTIONS - 1);

  // Indexed by {band, section}.
  localparam logic signed [COEF_WIDTH-1:0] A1_TAB [2*SECTIONS] = '{
    -12'sd1907, -12'sd1911, -12'sd1911, -12'sd1920,
    -12'sd1843, -12'sd1848, -12'sd1847, -12'sd1859
  };
  localparam logic signed [COEF_WIDTH-1:0] A2_TAB [2*SECTIONS] = '{
    12'sd1012, 12'sd1012, 12'sd1019, 12'sd1019,
    12'sd1009, 12'sd1009, 12'sd1018, 12'sd1018
  };
  // Set where b1 is -2048 instead of +2048, indexed by section.
  localparam logic [SECTIONS-1:0] B1_NEG = 4'b1100;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_A1_D1,
    MUL_A2_D0,
    MUL_GAIN_ACC
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_X,
    ACC_SUB_P,
    ACC_Y1_D0,
    ACC_ADD_B1D1
  } acc_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_LOOP,
    JMP_DONE
  } jmp_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    mul_sel_t            mul_sel;
    acc_op_t             acc_op;
    logic                dly_wr;
    logic                emit;
    jmp_t                jmp;
    logic [PC_WIDTH-1:0] target;
  } ucode_t;

  typedef struct packed {
    mul_sel_t             mul_sel;
    acc_op_t              acc_op;
    logic                 dly_wr;
    logic                 first;
    logic [SEC_WIDTH-1:0] sec;
  } lane_ctl_t;

  // Signed division by 2^k that truncates toward zero.
  function automatic logic signed [STATE_WIDTH-1:0] sdiv_pow2(
    input logic signed [STATE_WIDTH-1:0] v,
    input int                            k
  );
    logic [STATE_WIDTH-1:0]        mask;
    logic signed [STATE_WIDTH-1:0] sum;
    mask = (STATE_WIDTH'(1) << k) - STATE_WIDTH'(1);
    sum  = v + (v[STATE_WIDTH-1] ? $signed(mask) : '0);
    return sum >>> k;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_WIDTH-1:0] pc);
    ucode_t uw;
    uw = '{mul_sel: MUL_IDLE, acc_op: ACC_HOLD, dly_wr: 1'b0, emit: 1'b0,
           jmp: JMP_NEXT, target: STEP_A1};
    case (pc)
      STEP_A1: begin
        uw.mul_sel = MUL_A1_D1;
        uw.acc_op  = ACC_LOAD_X;
      end
      STEP_A2: begin
        uw.mul_sel = MUL_A2_D0;
        uw.acc_op  = ACC_SUB_P;
      end
      STEP_W: begin
        uw.acc_op = ACC_SUB_P;
      end
      STEP_Y1: begin
        uw.acc_op = ACC_Y1_D0;
      end
      STEP_B1: begin
        uw.acc_op = ACC_ADD_B1D1;
        uw.dly_wr = 1'b1;
      end
      STEP_GAIN: begin
        uw.mul_sel = MUL_GAIN_ACC;
        uw.jmp     = JMP_LOOP;
        uw.target  = STEP_A1;
      end
      STEP_OUTPUT: begin
        uw.emit = 1'b1;
        uw.jmp  = JMP_DONE;
      end
      default: begin
        uw.jmp = JMP_DONE;
      end
    endcase
    return uw;
  endfunction

endpackage

@@ rtl/dbbf_lane.sv @@
// One band's datapath: section delay words, shared multiplier and accumulator.
module dbbf_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dbbf_pkg::lane_ctl_t                  ctl,
  input  logic                                 band,
  input  logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] sample,
  input  logic [dbbf_pkg::GAIN_WIDTH-1:0]      gain,
  output logic [dbbf_pkg::OUT_WIDTH-1:0]       chain_out
);

  localparam int SW = dbbf_pkg::STATE_WIDTH;
  localparam int CW = dbbf_pkg::COEF_WIDTH;

  logic signed [SW-1:0] d0_mem [dbbf_pkg::SECTIONS];
  logic signed [SW-1:0] d1_mem [dbbf_pkg::SECTIONS];
  logic signed [SW-1:0] acc;
  logic signed [SW-1:0] acc_next;
  logic signed [SW-1:0] p;
  logic signed [SW-1:0] wq;
  logic signed [SW-1:0] d0;
  logic signed [SW-1:0] d1;
  logic signed [SW-1:0] x_sect;
  logic signed [SW-1:0] x_in;
  logic signed [SW-1:0] y1;
  logic signed [SW-1:0] b1_term;
  logic signed [SW-1:0] mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [SW+CW-1:0] prod;
  logic [dbbf_pkg::SEC_WIDTH:0] coef_idx;

  always_comb begin
    coef_idx = {band, ctl.sec};
    d0       = d0_mem[ctl.sec];
    d1       = d1_mem[ctl.sec];
    x_sect   = dbbf_pkg::sdiv_pow2(p, dbbf_pkg::GAIN_SHIFT);
    x_in     = ctl.first ? SW'(sample) : x_sect;
    y1       = dbbf_pkg::sdiv_pow2(acc <<< dbbf_pkg::Q_SHIFT, dbbf_pkg::Q_SHIFT);
    b1_term  = dbbf_pkg::B1_NEG[ctl.sec] ? -(d1 <<< dbbf_pkg::B1_SHIFT)
                                         : (d1 <<< dbbf_pkg::B1_SHIFT);
    chain_out = x_sect[dbbf_pkg::OUT_WIDTH-1:0];
  end

  always_comb begin
    case (ctl.mul_sel)
      dbbf_pkg::MUL_A1_D1: begin
        mul_a = d1;
        mul_b = dbbf_pkg::A1_TAB[coef_idx];
      end
      dbbf_pkg::MUL_A2_D0: begin
        mul_a = d0;
        mul_b = dbbf_pkg::A2_TAB[coef_idx];
      end
      dbbf_pkg::MUL_GAIN_ACC: begin
        mul_a = acc;
        mul_b = $signed(CW'(gain));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    case (ctl.acc_op)
      dbbf_pkg::ACC_LOAD_X:   acc_next = x_in <<< dbbf_pkg::Q_SHIFT;
      dbbf_pkg::ACC_SUB_P:    acc_next = acc - p;
      dbbf_pkg::ACC_Y1_D0:    acc_next = y1 + (d0 <<< dbbf_pkg::Q_SHIFT);
      dbbf_pkg::ACC_ADD_B1D1: acc_next = acc + b1_term;
      default:                acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (ctl.mul_sel != dbbf_pkg::MUL_IDLE) begin
      p <= prod[SW-1:0];
    end
    if (ctl.acc_op == dbbf_pkg::ACC_Y1_D0) begin
      wq <= dbbf_pkg::sdiv_pow2(acc, dbbf_pkg::Q_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dbbf_pkg::SECTIONS; i++) begin
        d0_mem[i] <= '0;
        d1_mem[i] <= '0;
      end
    end else if (ctl.dly_wr) begin
      d0_mem[ctl.sec] <= d1;
      d1_mem[ctl.sec] <= wq;
    end
  end

endmodule

@@ rtl/dual_band_biquad_filter_bank.sv @@
// Top level: stream ports, APB registers, microcode sequencer and two band lanes.
// Each sample runs six microcode steps for each of the four sections, on one
// multiplier per band, then one output step, which waits while an earlier result
// is not taken, and the sequencer then returns to idle.
// The block takes no new item while a sample is in work; a finished result waits in
// the output register. Synchronous reset clears the delay words and the sequencer
// and sets output_offset to 512 and section_gain to 8.
module dual_band_biquad_filter_bank (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // Bits from low: sample [11:0], zero padding.
  input  logic [dbbf_pkg::S_TDATA_WIDTH-1:0]    s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // Bits from low: low_band_out [15:0], high_band_out [31:16].
  output logic [dbbf_pkg::M_TDATA_WIDTH-1:0]    m_tdata,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dbbf_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [dbbf_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [dbbf_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                  pready
);

  dbbf_pkg::seq_state_t state;
  dbbf_pkg::seq_state_t state_next;
  logic [dbbf_pkg::PC_WIDTH-1:0]  pc;
  logic [dbbf_pkg::PC_WIDTH-1:0]  pc_next;
  logic [dbbf_pkg::SEC_WIDTH-1:0] sec;
  logic [dbbf_pkg::SEC_WIDTH-1:0] sec_next;
  dbbf_pkg::ucode_t               uw;
  dbbf_pkg::lane_ctl_t            lane_ctl;
  logic                           busy;
  logic                           stall;
  logic                           emit_fire;
  logic                           cfg_wr;

  logic [dbbf_pkg::OFFSET_WIDTH-1:0]       output_offset;
  logic [dbbf_pkg::GAIN_WIDTH-1:0]         section_gain;
  logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] sample;
  logic [dbbf_pkg::OUT_WIDTH-1:0]          low_chain;
  logic [dbbf_pkg::OUT_WIDTH-1:0]          high_chain;
  logic [dbbf_pkg::OUT_WIDTH-1:0]          low_band_out;
  logic [dbbf_pkg::OUT_WIDTH-1:0]          high_band_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_offset <= dbbf_pkg::OFFSET_RESET;
      section_gain  <= dbbf_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      case (paddr[dbbf_pkg::REG_SEL_BIT])
        dbbf_pkg::REG_OFFSET: output_offset <= pwdata[dbbf_pkg::OFFSET_WIDTH-1:0];
        dbbf_pkg::REG_GAIN:   section_gain  <= pwdata[dbbf_pkg::GAIN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[dbbf_pkg::REG_SEL_BIT])
      dbbf_pkg::REG_OFFSET: prdata = dbbf_pkg::APB_DATA_WIDTH'(output_offset);
      dbbf_pkg::REG_GAIN:   prdata = dbbf_pkg::APB_DATA_WIDTH'(section_gain);
      default:              prdata = '0;
    endcase
  end

  assign uw    = dbbf_pkg::ucode_rom(pc);
  assign busy  = (state == dbbf_pkg::SEQ_RUN);
  assign stall = uw.emit && m_tvalid && !m_tready;

  always_comb begin
    state_next = state;
    pc_next    = pc;
    sec_next   = sec;
    case (state)
      dbbf_pkg::SEQ_IDLE: begin
        pc_next  = dbbf_pkg::STEP_A1;
        sec_next = '0;
        if (s_tvalid) begin
          state_next = dbbf_pkg::SEQ_RUN;
        end
      end
      dbbf_pkg::SEQ_RUN: begin
        if (!stall) begin
          case (uw.jmp)
            dbbf_pkg::JMP_LOOP: begin
              if (sec != dbbf_pkg::LAST_SECTION) begin
                pc_next  = uw.target;
                sec_next = sec + 1'b1;
              end else begin
                pc_next = pc + 1'b1;
              end
            end
            dbbf_pkg::JMP_DONE: begin
              state_next = dbbf_pkg::SEQ_IDLE;
              pc_next    = dbbf_pkg::STEP_A1;
              sec_next   = '0;
            end
            default: begin
              pc_next = pc + 1'b1;
            end
          endcase
        end
      end
      default: begin
        state_next = dbbf_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready         = !busy;
    emit_fire        = busy && uw.emit && !stall;
    lane_ctl.mul_sel = (busy && !stall) ? uw.mul_sel : dbbf_pkg::MUL_IDLE;
    lane_ctl.acc_op  = (busy && !stall) ? uw.acc_op : dbbf_pkg::ACC_HOLD;
    lane_ctl.dly_wr  = busy && uw.dly_wr;
    lane_ctl.first   = (sec == '0);
    lane_ctl.sec     = sec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbbf_pkg::SEQ_IDLE;
      pc    <= dbbf_pkg::STEP_A1;
      sec   <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      sec   <= sec_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sample <= $signed(s_tdata[dbbf_pkg::SAMPLE_WIDTH-1:0]);
    end
  end

  dbbf_lane u_low (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .band      (dbbf_pkg::BAND_LOW),
    .sample    (sample),
    .gain      (section_gain),
    .chain_out (low_chain)
  );

  dbbf_lane u_high (
    .clk       (clk),
    .rst       (rst),
    .ctl       (lane_ctl),
    .band      (dbbf_pkg::BAND_HIGH),
    .sample    (sample),
    .gain      (section_gain),
    .chain_out (high_chain)
  );

  assign low_band_out  = low_chain + dbbf_pkg::OUT_WIDTH'(output_offset);
  assign high_band_out = high_chain + dbbf_pkg::OUT_WIDTH'(output_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      m_tdata <= {high_band_out, low_band_out};
    end
  end

endmodule

@@ rtl/dbbf_checker.sv @@
// Port-level checker for the dual-band filter bank and its bind statement.
module dbbf_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [dbbf_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [dbbf_pkg::APB_ADDR_WIDTH-1:0] paddr,
  input logic [dbbf_pkg::APB_DATA_WIDTH-1:0] pwdata,
  input logic [dbbf_pkg::APB_DATA_WIDTH-1:0] prdata,
  input logic                                pready
);

  logic in_txn;
  logic cfg_offset_wr;

  assign in_txn        = s_tvalid && s_tready;
  assign cfg_offset_wr = psel && penable && pwrite && pready
                         && (paddr[dbbf_pkg::REG_SEL_BIT] == dbbf_pkg::REG_OFFSET);

  // A stalled result holds its data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // An accepted transaction makes the block busy and holds s_tready low.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_txn |=> !s_tready ##1 !s_tready)
    else $error("input accepted while a sample is in work");

  // A result only appears at the end of a sample's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a sample in work");

  // A written offset reads back.
  a_offset_readback: assert property (@(posedge clk) disable iff (rst)
    cfg_offset_wr |=> (paddr[dbbf_pkg::REG_SEL_BIT] != dbbf_pkg::REG_OFFSET)
      || (prdata[dbbf_pkg::OFFSET_WIDTH-1:0] == $past(pwdata[dbbf_pkg::OFFSET_WIDTH-1:0])))
    else $error("offset register read back wrong");

endmodule

bind dual_band_biquad_filter_bank dbbf_checker u_dbbf_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench for the dual-band biquad filter bank, with its own band predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 11;
  localparam int GAIN_DIVISOR   = 1 << dbbf_pkg::GAIN_SHIFT;
  localparam int Q_UNITY        = 1 << dbbf_pkg::Q_SHIFT;
  localparam int B1_MAG         = 1 << dbbf_pkg::B1_SHIFT;

  localparam logic [dbbf_pkg::APB_ADDR_WIDTH-1:0] ADDR_OFFSET =
    dbbf_pkg::APB_ADDR_WIDTH'(dbbf_pkg::REG_OFFSET) << dbbf_pkg::REG_SEL_BIT;
  localparam logic [dbbf_pkg::APB_ADDR_WIDTH-1:0] ADDR_GAIN =
    dbbf_pkg::APB_ADDR_WIDTH'(dbbf_pkg::REG_GAIN) << dbbf_pkg::REG_SEL_BIT;

  localparam int FEEDBACK_A1 [8] = '{-1907, -1911, -1911, -1920, -1843, -1848, -1847, -1859};
  localparam int FEEDBACK_A2 [8] = '{1012, 1012, 1019, 1019, 1009, 1009, 1018, 1018};
  localparam int FEEDFWD_B1 [8]  = '{B1_MAG, B1_MAG, -B1_MAG, -B1_MAG,
                                     B1_MAG, B1_MAG, -B1_MAG, -B1_MAG};

  typedef struct packed {
    logic [dbbf_pkg::OUT_WIDTH-1:0] high_band;
    logic [dbbf_pkg::OUT_WIDTH-1:0] low_band;
  } band_pair_t;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                s_tvalid;
  logic                                s_tready;
  // Bits from low: sample [11:0], zero padding.
  logic [dbbf_pkg::S_TDATA_WIDTH-1:0]  s_tdata;
  logic                                m_tvalid;
  logic                                m_tready;
  // Bits from low: low_band_out [15:0], high_band_out [31:16].
  logic [dbbf_pkg::M_TDATA_WIDTH-1:0]  m_tdata;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [dbbf_pkg::APB_ADDR_WIDTH-1:0] paddr;
  logic [dbbf_pkg::APB_DATA_WIDTH-1:0] pwdata;
  logic [dbbf_pkg::APB_DATA_WIDTH-1:0] prdata;
  logic                                pready;

  int                                section_delay [16];
  logic [dbbf_pkg::OFFSET_WIDTH-1:0] offset_copy;
  logic [dbbf_pkg::GAIN_WIDTH-1:0]   gain_copy;
  band_pair_t                        pending_outputs [$];
  int                                error_count;
  int                                tx_gap_pct;
  int                                rx_stall_pct;
  int                                idle_cycles = 0;

  dual_band_biquad_filter_bank i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int run_biquad(input int sec, input int x);
    int d0;
    int d1;
    int w;
    int y;
    int g;
    d0 = section_delay[2*sec];
    d1 = section_delay[2*sec+1];
    g  = gain_copy;
    w  = x * Q_UNITY - FEEDBACK_A1[sec] * d1 - FEEDBACK_A2[sec] * d0;
    y  = (w * Q_UNITY) / Q_UNITY;
    y  = y + FEEDFWD_B1[sec] * d1 + Q_UNITY * d0;
    section_delay[2*sec]   = d1;
    section_delay[2*sec+1] = w / Q_UNITY;
    return (y * g) / GAIN_DIVISOR;
  endfunction

  function automatic logic [dbbf_pkg::OUT_WIDTH-1:0] run_band(input int first, input int x);
    int v;
    int off;
    v   = x;
    off = offset_copy;
    for (int k = 0; k < dbbf_pkg::SECTIONS; k++) begin
      v = run_biquad(first + k, v);
    end
    v = v + off;
    return v[dbbf_pkg::OUT_WIDTH-1:0];
  endfunction

  function automatic band_pair_t predict_band_outputs(
    input logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] smp
  );
    band_pair_t r;
    int x;
    x           = smp;
    r.low_band  = run_band(0, x);
    r.high_band = run_band(dbbf_pkg::SECTIONS, x);
    return r;
  endfunction

  function automatic logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] pick_sample(
    input logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] prev
  );
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 50) begin
      return dbbf_pkg::SAMPLE_WIDTH'($urandom);
    end else if (mode < 75) begin
      return dbbf_pkg::SAMPLE_WIDTH'($urandom_range(0, 128) - 64);
    end else if (mode < 90) begin
      case ($urandom_range(0, 3))
        0: return dbbf_pkg::SAMPLE_WIDTH'(2047);
        1: return dbbf_pkg::SAMPLE_WIDTH'(-2048);
        2: return dbbf_pkg::SAMPLE_WIDTH'(0);
        default: return dbbf_pkg::SAMPLE_WIDTH'(-1);
      endcase
    end
    return prev + dbbf_pkg::SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
  endfunction

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    band_pair_t want;
    band_pair_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (got.low_band !== want.low_band) begin
          $display("%0t: low_band_out mismatch, expected %0d, actual %0d", $time,
                   $signed(want.low_band), $signed(got.low_band));
          error_count++;
        end
        if (got.high_band !== want.high_band) begin
          $display("%0t: high_band_out mismatch, expected %0d, actual %0d", $time,
                   $signed(want.high_band), $signed(got.high_band));
          error_count++;
        end
      end
    end
  end

  initial begin
    int hold;
    hold = 0;
    m_tready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_stall_pct) begin
        hold = $urandom_range(0, 5);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] smp);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {{(dbbf_pkg::S_TDATA_WIDTH-dbbf_pkg::SAMPLE_WIDTH){1'b0}}, smp};
    do @(posedge clk); while (!s_tready);
    pending_outputs.push_back(predict_band_outputs(smp));
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [dbbf_pkg::APB_ADDR_WIDTH-1:0] addr,
                           input logic [dbbf_pkg::APB_DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_OFFSET) begin
      offset_copy = data[dbbf_pkg::OFFSET_WIDTH-1:0];
    end else if (addr == ADDR_GAIN) begin
      gain_copy = data[dbbf_pkg::GAIN_WIDTH-1:0];
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_filter_config(input logic [dbbf_pkg::OFFSET_WIDTH-1:0] offset,
                                   input logic [dbbf_pkg::GAIN_WIDTH-1:0] gain,
                                   input bit junk_upper);
    logic [dbbf_pkg::APB_DATA_WIDTH-1:0] hi;
    hi = junk_upper ? dbbf_pkg::APB_DATA_WIDTH'($urandom) : '0;
    apb_write(ADDR_OFFSET, {hi[dbbf_pkg::APB_DATA_WIDTH-1:dbbf_pkg::OFFSET_WIDTH], offset});
    @(posedge clk);
    apb_write(ADDR_GAIN, {hi[dbbf_pkg::APB_DATA_WIDTH-1:dbbf_pkg::GAIN_WIDTH], gain});
    @(posedge clk);
  endtask

  task automatic test_extreme_samples();
    logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] pattern [10];
    pattern = '{12'sd2047, -12'sd2048, 12'sd0, 12'sd1, -12'sd1,
                12'sd1365, -12'sd1366, 12'sd2047, 12'sd2047, -12'sd2048};
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    foreach (pattern[i]) send_sample(pattern[i]);
    drain_outputs();
  endtask

  task automatic test_gain_offset_corners();
    // A gain of zero silences the output of every section.
    set_filter_config(dbbf_pkg::OFFSET_WIDTH'(0), dbbf_pkg::GAIN_WIDTH'(0), 1'b0);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(12'sd0);
    send_sample(12'sd700);
    drain_outputs();
    // The largest register values drive the chains into wrap-around.
    set_filter_config(dbbf_pkg::OFFSET_WIDTH'(1023), dbbf_pkg::GAIN_WIDTH'(31), 1'b1);
    send_sample(12'sd2047);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(-12'sd2048);
    drain_outputs();
    set_filter_config(dbbf_pkg::OFFSET_WIDTH'(1023), dbbf_pkg::GAIN_WIDTH'(1), 1'b1);
    send_sample(-12'sd2048);
    send_sample(12'sd2047);
    send_sample(12'sd0);
    drain_outputs();
  endtask

  task automatic test_random_stream();
    logic signed [dbbf_pkg::SAMPLE_WIDTH-1:0] smp;
    logic [dbbf_pkg::OFFSET_WIDTH-1:0]        off;
    logic [dbbf_pkg::GAIN_WIDTH-1:0]          gain;
    smp = '0;
    for (int ph = 0; ph < PHASES; ph++) begin
      off  = dbbf_pkg::OFFSET_WIDTH'($urandom_range(0, 1023));
      gain = dbbf_pkg::GAIN_WIDTH'($urandom_range(1, 16));
      if (ph == 0) begin
        off  = dbbf_pkg::OFFSET_WIDTH'(1023);
        gain = dbbf_pkg::GAIN_WIDTH'(16);
      end else if (ph == 1) begin
        off  = dbbf_pkg::OFFSET_WIDTH'(0);
        gain = dbbf_pkg::GAIN_WIDTH'(1);
      end else if ($urandom_range(0, 4) == 0) begin
        gain = dbbf_pkg::GAIN_WIDTH'($urandom_range(0, 31));
      end
      set_filter_config(off, gain, ph[0]);
      if (ph == PHASES - 1) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end else begin
        tx_gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
        rx_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          drain_outputs();
        end
        smp = pick_sample(smp);
        send_sample(smp);
      end
      drain_outputs();
    end
  endtask

  initial begin
    s_tvalid     <= 1'b0;
    s_tdata      <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    error_count  = 0;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    offset_copy  = dbbf_pkg::OFFSET_WIDTH'(512);
    gain_copy    = dbbf_pkg::GAIN_WIDTH'(8);
    foreach (section_delay[i]) section_delay[i] = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extreme_samples();
    test_gain_offset_corners();
    test_random_stream();

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
